// File: sv/ufrm_pkg.sv
// Shared types and constants for the UART register model block.
package ufrm_pkg;

  // Input item kinds on the action field.
  localparam logic [1:0] ACT_READ = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX_CHAR = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  // Register offsets.
  localparam logic [7:0] REG_DATA = 8'd0;
  localparam logic [7:0] REG_STATUS = 8'd1;

  // Status register bit positions.
  localparam int BIT_RXEMPTY = 0;
  localparam int BIT_RXIEN = 1;
  localparam int BIT_TXEMPTY = 2;
  localparam int BIT_TXIEN = 3;

  localparam logic [7:0] NEWLINE = 8'h0A;

  // Largest number of bytes one tick may drain.
  localparam int MAX_RESULTS = 16;
  localparam int NW = $clog2(MAX_RESULTS);

  typedef enum logic [2:0] {
    CMD_RD_DATA   = 3'd0,
    CMD_RD_STATUS = 3'd1,
    CMD_WR_DATA   = 3'd2,
    CMD_WR_STATUS = 3'd3,
    CMD_BAD       = 3'd4,
    CMD_RX        = 3'd5,
    CMD_TICK      = 3'd6
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_out;
    logic       irq;
    logic       bad_address;
    logic       last;
  } res_t;

endpackage

// File: sv/ufrm_front.sv
// Front end: classifies each request and holds it in a two-entry command queue.
module ufrm_front
  import ufrm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] rx_char_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t       cmd_new;
  cmd_t       queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    cmd_new.data = wdata_i;
    case (action_i)
      ACT_READ: begin
        if (reg_addr_i == REG_DATA) cmd_new.kind = CMD_RD_DATA;
        else if (reg_addr_i == REG_STATUS) cmd_new.kind = CMD_RD_STATUS;
        else cmd_new.kind = CMD_BAD;
      end
      ACT_WRITE: begin
        if (reg_addr_i == REG_DATA) cmd_new.kind = CMD_WR_DATA;
        else if (reg_addr_i == REG_STATUS) cmd_new.kind = CMD_WR_STATUS;
        else cmd_new.kind = CMD_BAD;
      end
      ACT_RX_CHAR: begin
        cmd_new.kind = CMD_RX;
        cmd_new.data = rx_char_i;
      end
      ACT_TICK: cmd_new.kind = CMD_TICK;
      default: cmd_new.kind = CMD_BAD;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cmd_new;
  end

endmodule

// File: sv/ufrm_byte_fifo.sv
// Byte FIFO with a registered head read and write-to-head forwarding.
module ufrm_byte_fifo
  import ufrm_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [7:0]    data_i,
  input  logic          pop_i,
  output logic [7:0]    head_o,
  output logic [CW-1:0] count_o,
  output logic          full_o,
  output logic          empty_o
);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    ptr_inc = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign head_o  = rdata_q;

  // A push to a full FIFO is dropped.
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    head_d = do_pop ? ptr_inc(head_q) : head_q;
    tail_d = do_push ? ptr_inc(tail_q) : tail_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // The read port always tracks the next head, so the oldest byte is ready
  // in the cycle after any pointer move.
  always_ff @(posedge clk_i) begin
    if (do_push) mem[tail_q] <= data_i;
    if (do_push && (tail_q == head_d)) rdata_q <= data_i;
    else rdata_q <= mem[head_d];
  end

endmodule

// File: sv/ufrm_back.sv
// Back end: executes queued commands on the FIFOs and registers each result.
module ufrm_back
  import ufrm_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e        st_q, st_d;
  logic [NW-1:0] n_q, n_d;
  logic          flush_q, flush_d;
  logic          rx_ien_q, rx_ien_d;
  logic          tx_ien_q, tx_ien_d;
  logic          out_valid_q;
  res_t          res_q, res_d;
  logic          res_load;
  logic          out_free;
  logic          final_byte;

  logic          rx_push, rx_pop, tx_push, tx_pop;
  logic [7:0]    rx_head, tx_head;
  logic [CW-1:0] rx_cnt, tx_cnt;
  logic          rx_full, rx_empty, tx_full, tx_empty;

  ufrm_byte_fifo #(.DEPTH(FIFO_DEPTH)) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rx_push),
    .data_i  (cmd_i.data),
    .pop_i   (rx_pop),
    .head_o  (rx_head),
    .count_o (rx_cnt),
    .full_o  (rx_full),
    .empty_o (rx_empty)
  );

  ufrm_byte_fifo #(.DEPTH(FIFO_DEPTH)) u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tx_push),
    .data_i  (cmd_i.data),
    .pop_i   (tx_pop),
    .head_o  (tx_head),
    .count_o (tx_cnt),
    .full_o  (tx_full),
    .empty_o (tx_empty)
  );

  // A full receive FIFO or an empty transmit FIFO raises the interrupt, each gated by its enable.
  function automatic logic irq_of(input logic tx_empty_after, input logic rx_full_now,
                                  input logic rx_ien, input logic tx_ien);
    irq_of = (rx_ien && rx_full_now) || (tx_ien && tx_empty_after);
  endfunction

  assign out_free    = !out_valid_q || out_ready_i;
  assign final_byte  = (tx_cnt == CW'(1)) || (n_q == NW'(MAX_RESULTS - 1));
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    st_d      = st_q;
    n_d       = n_q;
    flush_d   = flush_q;
    rx_ien_d  = rx_ien_q;
    tx_ien_d  = tx_ien_q;
    res_d     = '0;
    res_load  = 1'b0;
    cmd_pop_o = 1'b0;
    rx_push   = 1'b0;
    rx_pop    = 1'b0;
    tx_push   = 1'b0;
    tx_pop    = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          res_d.last = 1'b1;
          res_load   = 1'b1;
          cmd_pop_o  = 1'b1;
          case (cmd_i.kind)
            CMD_RD_DATA: begin
              res_d.read_data = rx_empty ? 8'd0 : rx_head;
              rx_pop          = !rx_empty;
            end
            CMD_RD_STATUS: begin
              res_d.read_data[BIT_RXEMPTY] = rx_empty;
              res_d.read_data[BIT_RXIEN]   = rx_ien_q;
              res_d.read_data[BIT_TXEMPTY] = tx_empty;
              res_d.read_data[BIT_TXIEN]   = tx_ien_q;
            end
            CMD_WR_DATA: begin
              tx_push = 1'b1;
              if (cmd_i.data == NEWLINE) flush_d = 1'b1;
            end
            CMD_WR_STATUS: begin
              rx_ien_d = cmd_i.data[BIT_RXIEN];
              tx_ien_d = cmd_i.data[BIT_TXIEN];
            end
            CMD_RX: rx_push = 1'b1;
            CMD_TICK: begin
              if (tx_full || flush_q) begin
                flush_d = 1'b0;
              end
              if ((tx_full || flush_q) && !tx_empty) begin
                // The bytes themselves carry the results of this request.
                res_load  = 1'b0;
                cmd_pop_o = 1'b0;
                n_d       = '0;
                st_d      = ST_DRAIN;
              end else begin
                res_d.irq = irq_of(tx_empty, rx_full, rx_ien_q, tx_ien_q);
              end
            end
            default: res_d.bad_address = 1'b1;
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          tx_pop         = 1'b1;
          res_load       = 1'b1;
          res_d.tx_valid = 1'b1;
          res_d.tx_out   = tx_head;
          n_d            = n_q + 1'b1;
          if (final_byte) begin
            res_d.last = 1'b1;
            res_d.irq  = irq_of(tx_cnt == CW'(1), rx_full, rx_ien_q, tx_ien_q);
            cmd_pop_o  = 1'b1;
            st_d       = ST_IDLE;
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      n_q         <= '0;
      flush_q     <= 1'b0;
      rx_ien_q    <= 1'b0;
      tx_ien_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      n_q      <= n_d;
      flush_q  <= flush_d;
      rx_ien_q <= rx_ien_d;
      tx_ien_q <= tx_ien_d;
      if (res_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
  end

  a_rx_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt <= CW'(FIFO_DEPTH))
    else $error("receive FIFO count beyond depth");

  a_tx_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_cnt <= CW'(FIFO_DEPTH))
    else $error("transmit FIFO count beyond depth");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DRAIN) |-> !tx_empty)
    else $error("draining an empty transmit FIFO");

  a_drain_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res_d.tx_valid) |=> (tx_cnt == $past(tx_cnt) - 1'b1))
    else $error("drained byte did not leave the transmit FIFO");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !res_load)
    else $error("result overwritten while stalled");

endmodule

// File: sv/uart_fifo_register_model_top.sv
// Top level of the UART register model with receive and transmit FIFOs.
//
// Requests arrive on the input channel (in_valid_i/in_ready_o): a bus read or
// write of the data or status register, a received character, or a tick.
// Results leave on the output channel (out_valid_o/out_ready_i); last_o marks
// the final result of each request.
// A request is classified and queued in a two-entry command queue; the
// execution stage then takes it and registers its result in the output
// register. Bus accesses and received characters each pass through the
// execution stage once, giving one request per cycle when the output is
// taken at once. A draining tick first enters the drain state and then
// yields one result per transmitted byte, up to 16 bytes; the transmit FIFO
// read port delivers one byte per cycle while the output is taken.
// Reset clears the FIFO counts and pointers, the flush mark and both
// interrupt enables; the FIFO storage itself is not cleared.
// When the receiver stalls, the result is held in the output register, the
// execution stage waits, and the input side keeps accepting until the
// command queue is full.
module uart_fifo_register_model_top
  import ufrm_pkg::*;
#(
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] rx_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_out_o,
  output logic       irq_o,
  output logic       bad_address_o,
  output logic       last_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  res_t res;

  ufrm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .reg_addr_i  (reg_addr_i),
    .wdata_i     (wdata_i),
    .rx_char_i   (rx_char_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  ufrm_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign read_data_o   = res.read_data;
  assign tx_valid_o    = res.tx_valid;
  assign tx_out_o      = res.tx_out;
  assign irq_o         = res.irq;
  assign bad_address_o = res.bad_address;
  assign last_o        = res.last;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the UART register block with receive and transmit FIFOs.
module testbench;
  import ufrm_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam int LONG_STALL = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic [7:0] rx_char;
  } uart_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  uart_req_t cur_req = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] read_data_o;
  logic       tx_valid_o;
  logic [7:0] tx_out_o;
  logic       irq_o;
  logic       bad_address_o;
  logic       last_o;

  uart_req_t pending_requests[$];
  res_t      expected_results[$];

  // Predicted state of the block.
  logic [7:0] rx_bytes[FIFO_DEPTH];
  logic [7:0] tx_bytes[FIFO_DEPTH];
  int         rx_level = 0;
  int         rx_first = 0;
  int         tx_level = 0;
  int         tx_first = 0;
  logic       flush_mark = 1'b0;
  logic       rx_ien = 1'b0;
  logic       tx_ien = 1'b0;

  int   send_idle_pct = 6;
  int   recv_idle_pct = 85;
  logic req_taken = 1'b0;
  logic long_stall_go = 1'b0;
  logic long_stall_seen = 1'b0;
  int   stall_count = 0;
  int   quiet_cycles = 0;

  int queued_requests = 0;
  int accepted_requests = 0;
  int checked_results = 0;
  int line_bytes = 0;
  int bad_accesses = 0;
  int mismatches = 0;

  uart_fifo_register_model_top #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .action_i     (cur_req.action),
    .reg_addr_i   (cur_req.reg_addr),
    .wdata_i      (cur_req.wdata),
    .rx_char_i    (cur_req.rx_char),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .read_data_o  (read_data_o),
    .tx_valid_o   (tx_valid_o),
    .tx_out_o     (tx_out_o),
    .irq_o        (irq_o),
    .bad_address_o(bad_address_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Works out the results of one accepted request and updates the predicted state.
  task automatic predict_uart_results(input uart_req_t r);
    res_t res;
    int   n_drain;
    res = '0;
    case (r.action)
      ACT_READ: begin
        if (r.reg_addr == REG_DATA) begin
          if (rx_level != 0) begin
            res.read_data = rx_bytes[rx_first];
            rx_first = (rx_first + 1) % FIFO_DEPTH;
            rx_level--;
          end
        end else if (r.reg_addr == REG_STATUS) begin
          res.read_data[BIT_RXEMPTY] = (rx_level == 0);
          res.read_data[BIT_RXIEN] = rx_ien;
          res.read_data[BIT_TXEMPTY] = (tx_level == 0);
          res.read_data[BIT_TXIEN] = tx_ien;
        end else begin
          res.bad_address = 1'b1;
          bad_accesses++;
        end
      end
      ACT_WRITE: begin
        if (r.reg_addr == REG_DATA) begin
          if (tx_level < FIFO_DEPTH) begin
            tx_bytes[(tx_first + tx_level) % FIFO_DEPTH] = r.wdata;
            tx_level++;
          end
          // A newline dropped by a full FIFO still requests a flush.
          if (r.wdata == NEWLINE) flush_mark = 1'b1;
        end else if (r.reg_addr == REG_STATUS) begin
          rx_ien = r.wdata[BIT_RXIEN];
          tx_ien = r.wdata[BIT_TXIEN];
        end else begin
          res.bad_address = 1'b1;
          bad_accesses++;
        end
      end
      ACT_RX_CHAR: begin
        if (rx_level < FIFO_DEPTH) begin
          rx_bytes[(rx_first + rx_level) % FIFO_DEPTH] = r.rx_char;
          rx_level++;
        end
      end
      default: begin
        n_drain = 0;
        if (tx_level >= FIFO_DEPTH || flush_mark) begin
          n_drain = (tx_level < MAX_RESULTS) ? tx_level : MAX_RESULTS;
          flush_mark = 1'b0;
        end
        for (int i = 0; i < n_drain; i++) begin
          res.tx_valid = 1'b1;
          res.tx_out = tx_bytes[tx_first];
          tx_first = (tx_first + 1) % FIFO_DEPTH;
          tx_level--;
          if (i != n_drain - 1) expected_results.push_back(res);
        end
        line_bytes += n_drain;
        // A full receive FIFO or an empty transmit FIFO raises the interrupt, each gated by its enable.
        res.irq = (rx_ien && rx_level >= FIFO_DEPTH) || (tx_ien && tx_level == 0);
      end
    endcase
    res.last = 1'b1;
    expected_results.push_back(res);
  endtask

  task automatic add_req(input logic [1:0] act, input logic [7:0] addr,
                         input logic [7:0] wd, input logic [7:0] rxc);
    uart_req_t r;
    r.action = act;
    r.reg_addr = addr;
    r.wdata = wd;
    r.rx_char = rxc;
    pending_requests.push_back(r);
    queued_requests++;
  endtask

  task automatic add_read(input logic [7:0] addr);
    add_req(ACT_READ, addr, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
  endtask

  task automatic add_write(input logic [7:0] addr, input logic [7:0] wd);
    add_req(ACT_WRITE, addr, wd, 8'($urandom_range(255, 0)));
  endtask

  task automatic add_rx(input logic [7:0] rxc);
    add_req(ACT_RX_CHAR, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)), rxc);
  endtask

  task automatic add_tick();
    add_req(ACT_TICK, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
            8'($urandom_range(255, 0)));
  endtask

  // Whole messages and receive bursts make up half the bursts; the rest are status accesses, lone ticks and garbage.
  task automatic add_random_burst();
    int kind;
    int n;
    kind = $urandom_range(9, 0);
    n = ($urandom_range(3, 0) == 0) ? $urandom_range(18, 14) : $urandom_range(6, 1);
    case (kind)
      0, 1, 2: begin
        for (int i = 0; i < n; i++) add_write(REG_DATA, 8'($urandom_range(255, 0)));
        if ($urandom_range(9, 0) < 7) add_write(REG_DATA, NEWLINE);
        add_tick();
      end
      3, 4: begin
        for (int i = 0; i < n; i++) add_rx(8'($urandom_range(255, 0)));
        if ($urandom_range(1, 0) == 1) add_tick();
        for (int i = 0; i <= n; i++)
          add_read(($urandom_range(7, 0) == 0) ? REG_STATUS : REG_DATA);
      end
      5: begin
        add_write(REG_STATUS, 8'($urandom_range(255, 0)));
        add_read(REG_STATUS);
      end
      6: add_tick();
      default: begin
        repeat ($urandom_range(3, 1))
          add_req(2'($urandom_range(3, 0)),
                  ($urandom_range(9, 0) < 6) ? 8'($urandom_range(255, 0))
                                             : 8'($urandom_range(1, 0)),
                  8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
      end
    endcase
  endtask

  task automatic add_random_requests(input int target);
    int start;
    start = queued_requests;
    while (queued_requests - start < target) add_random_burst();
  endtask

  task automatic wait_for_results();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Request driver: a new request is offered only once the previous one has gone.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || req_taken)) begin
      if (pending_requests.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        cur_req = pending_requests.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_ni && stall_count == 0 && $urandom_range(99, 0) >= recv_idle_pct;
  end

  // Long receiver hold-off, started once by the stimulus.
  always @(posedge clk_i) begin
    if (long_stall_go && !long_stall_seen) begin
      long_stall_seen <= 1'b1;
      stall_count <= LONG_STALL;
    end else if (stall_count != 0) begin
      stall_count <= stall_count - 1;
    end
  end

  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    req_taken = rst_ni && in_valid && in_ready_o;
    if (req_taken) begin
      predict_uart_results(cur_req);
      accepted_requests++;
    end
    if (rst_ni && out_valid_o && out_ready) begin
      got.read_data = read_data_o;
      got.tx_valid = tx_valid_o;
      got.tx_out = tx_out_o;
      got.irq = irq_o;
      got.bad_address = bad_address_o;
      got.last = last_o;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: rd=%02h txv=%b tx=%02h irq=%b bad=%b last=%b",
                   got.read_data, got.tx_valid, got.tx_out, got.irq, got.bad_address,
                   got.last);
      end else begin
        want = expected_results.pop_front();
        checked_results++;
        if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
            got.tx_out !== want.tx_out || got.irq !== want.irq ||
            got.bad_address !== want.bad_address || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch on result %0d: expected rd=%02h txv=%b tx=%02h irq=%b ",
                      "bad=%b last=%b, got rd=%02h txv=%b tx=%02h irq=%b bad=%b last=%b"},
                     checked_results, want.read_data, want.tx_valid, want.tx_out, want.irq,
                     want.bad_address, want.last, got.read_data, got.tx_valid, got.tx_out,
                     got.irq, got.bad_address, got.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Phase one: the sender is eager and the receiver mostly stalls.
    add_read(REG_STATUS);
    add_read(REG_DATA);
    add_read(8'hFF);
    add_write(8'h02, 8'hFF);
    add_write(8'h80, 8'h00);
    add_write(REG_STATUS, 8'hFF);
    add_read(REG_STATUS);
    add_tick();
    add_write(REG_STATUS, 8'hF5);
    add_read(REG_STATUS);
    add_rx(8'h00);
    add_rx(8'hFF);
    add_read(REG_STATUS);
    add_read(REG_DATA);
    add_read(REG_DATA);
    add_write(REG_DATA, 8'hFF);
    add_write(REG_DATA, 8'h00);
    add_tick();
    add_write(REG_DATA, NEWLINE);
    add_read(REG_STATUS);
    add_tick();
    add_write(REG_STATUS, NEWLINE);
    add_tick();
    add_write(REG_STATUS, 8'h00);
    add_random_requests(22);
    wait_for_results();

    // Phase two: the sender mostly idles and the receiver rarely stalls.
    send_idle_pct = 85;
    recv_idle_pct = 6;
    add_random_requests(22);
    wait_for_results();

    // Phase three: no idling, but the receiver holds off for a long stretch at the start.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_requests(22);
    @(negedge clk_i);
    long_stall_go = 1'b1;
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("Run covered %0d requests over three flow-control phases and a long output stall.",
             accepted_requests);
    $display("%0d results checked, %0d bytes drained to the line, %0d bad register accesses.",
             checked_results, line_bytes, bad_accesses);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ufrm_pkg.sv
sv/ufrm_front.sv
sv/ufrm_byte_fifo.sv
sv/ufrm_back.sv
sv/uart_fifo_register_model_top.sv
verif/testbench.sv
